/* sv/pidl_pkg.sv */
// Shared types and constants for the positional insert/delete list.
package pidl_pkg;

  // Field widths of the input and result items.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ELEM_W   = 8;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SIZE_W   = 5;

  // Packed tdata widths, rounded up to whole bytes.
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 16;

  // Packed tuser widths.
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TUSER_W = 1;

  // Action codes of an input item.
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  // Operation broadcast to every cell of the row.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } pidl_op_e;

  typedef struct packed {
    pidl_op_e          op;
    logic [POS_W-1:0]  pos;
    logic [ELEM_W-1:0] elem;
  } pidl_ctrl_t;

  // Sequencer states.
  typedef enum logic {
    S_IDLE,
    S_DUMP
  } pidl_state_e;

endpackage

/* sv/pidl_cell.sv */
// One storage cell of the list row, shifting with its neighbors.
module pidl_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                         clk_i,
  input  pidl_pkg::pidl_ctrl_t         ctrl_i,
  input  logic                         at_tail_i,
  input  logic [pidl_pkg::ELEM_W-1:0]  left_i,
  input  logic [pidl_pkg::ELEM_W-1:0]  right_i,
  input  logic [pidl_pkg::ELEM_W-1:0]  head_i,
  output logic [pidl_pkg::ELEM_W-1:0]  val_o
);
  import pidl_pkg::*;

  // Wide enough for any cell index and any position.
  localparam int unsigned CmpW = 9;
  localparam logic [CmpW-1:0] IDX_C = CmpW'(Idx);

  logic [ELEM_W-1:0] val_q, val_d;
  logic [CmpW-1:0]   pos_x;

  assign pos_x = CmpW'(ctrl_i.pos);

  // Insert opens a gap at the position, delete closes it, rotate walks
  // the occupied part one place toward the front.
  always_comb begin
    val_d = val_q;
    unique case (ctrl_i.op)
      OP_HOLD: val_d = val_q;
      OP_INS: begin
        if (IDX_C > pos_x) begin
          val_d = left_i;
        end else if (IDX_C == pos_x) begin
          val_d = ctrl_i.elem;
        end
      end
      OP_DEL: begin
        if (IDX_C >= pos_x) begin
          val_d = right_i;
        end
      end
      OP_ROT: val_d = at_tail_i ? head_i : right_i;
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

/* sv/positional_insert_delete_list.sv */
// Top level of the positional insert/delete list built from a row of cells.
//
// Input items arrive on the s_axis channel: an action (insert, delete or
// dump), a byte and a position. Results leave on the m_axis channel.
// When an insert or delete is taken, the whole row of cells shifts at once,
// and the single result (status and new size, tlast high) sits in the
// output register at the next edge. During a dump the row rotates one
// place a cycle over its occupied part while the output register is free,
// and the front cell feeds the output, so after N rotations of a list of N
// elements the contents are back in order. An empty dump answers at once
// with one status item. No new item is taken while a dump runs.
// When the receiver stalls, the output register holds its item and the
// dump pauses; an edit is taken only while the output register is free
// or being emptied in the same cycle.
// Reset empties the list; cell contents are not cleared and are never
// read above the current size.
module positional_insert_delete_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // element[7:0], position[12:8], zero [15:13]
  input  logic [pidl_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // action[1:0]
  input  logic [pidl_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[1:0], size[6:2], element_out[14:7], zero [15]
  output logic [pidl_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // element_valid[0]
  output logic [pidl_pkg::M_TUSER_W-1:0]     m_axis_tuser,
  output logic                               m_axis_tlast
);
  import pidl_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  // Input field decode.
  logic [ACTION_W-1:0] in_action;
  logic [ELEM_W-1:0]   in_element;
  logic [POS_W-1:0]    in_position;

  assign in_action   = s_axis_tuser[1:0];
  assign in_element  = s_axis_tdata[7:0];
  assign in_position = s_axis_tdata[12:8];

  pidl_state_e         state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    dump_idx_q, dump_idx_d;
  logic [CNT_W-1:0]    tail_idx;
  logic                out_free, in_accept, out_load, dump_last;
  logic [CMP_W-1:0]    pos_x, cnt_x;
  pidl_ctrl_t          ctrl;

  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [M_TUSER_W-1:0] m_user_q, m_user_d;
  logic                 m_last_q, m_last_d;

  logic [ELEM_W-1:0]   cell_val [CAPACITY];
  logic [ELEM_W-1:0]   left_w   [CAPACITY];
  logic [ELEM_W-1:0]   right_w  [CAPACITY];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign tail_idx      = count_q - CNT_W'(1);
  assign dump_last     = (dump_idx_q == tail_idx);
  assign pos_x         = CMP_W'(in_position);
  assign cnt_x         = CMP_W'(count_q);

  // Sequencer: decode edits, run the dump, fill the output register.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    dump_idx_d = dump_idx_q;
    out_load   = 1'b0;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    m_last_d   = m_last_q;
    ctrl.op    = OP_HOLD;
    ctrl.pos   = in_position;
    ctrl.elem  = in_element;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          logic [STATUS_W-1:0] st;
          logic                no_item;
          st      = ST_OK;
          no_item = 1'b0;
          priority if (in_action == ACT_INSERT) begin
            if (pos_x > cnt_x) begin
              st = ST_BADPOS;
            end else if (count_q == CAP_C) begin
              st = ST_FULL;
            end else begin
              ctrl.op = OP_INS;
              count_d = count_q + CNT_W'(1);
            end
          end else if (in_action == ACT_DELETE) begin
            if (count_q == '0) begin
              st = (in_position == '0) ? ST_EMPTY : ST_BADPOS;
            end else if (pos_x >= cnt_x) begin
              st = ST_BADPOS;
            end else begin
              ctrl.op = OP_DEL;
              count_d = count_q - CNT_W'(1);
            end
          end else if (in_action == ACT_DUMP) begin
            if (count_q == '0) begin
              st = ST_EMPTY;
            end else begin
              no_item    = 1'b1;
              state_d    = S_DUMP;
              dump_idx_d = '0;
            end
          end else begin
            st = ST_OK;
          end
          if (!no_item) begin
            out_load = 1'b1;
            m_data_d = {1'b0, {ELEM_W{1'b0}}, SIZE_W'(count_d), st};
            m_user_d = 1'b0;
            m_last_d = 1'b1;
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_load   = 1'b1;
          m_data_d   = {1'b0, cell_val[0], SIZE_W'(count_q), ST_OK};
          m_user_d   = 1'b1;
          m_last_d   = dump_last;
          ctrl.op    = OP_ROT;
          dump_idx_d = dump_idx_q + CNT_W'(1);
          if (dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      dump_idx_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      dump_idx_q <= dump_idx_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= m_data_d;
      m_user_q <= m_user_d;
      m_last_q <= m_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // Row of cells with neighbor links.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = in_element;
    end else begin : g_mid_l
      assign left_w[i] = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_lastc
      assign right_w[i] = cell_val[0];
    end else begin : g_mid_r
      assign right_w[i] = cell_val[i+1];
    end

    pidl_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .at_tail_i (tail_idx == CNT_W'(i)),
      .left_i    (left_w[i]),
      .right_i   (right_w[i]),
      .head_i    (cell_val[0]),
      .val_o     (cell_val[i])
    );
  end

  // The list never holds more than its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CAP_C)
    else $error("list size above capacity");

  // Nothing is taken in while a dump is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |-> !s_axis_tready)
    else $error("input taken during dump");

  // A dump leaves the size untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) |=> (count_q == $past(count_q)))
    else $error("size changed during dump");

  // The final dumped element ends the dump.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP && out_free && dump_last) |=> (state_q == S_IDLE && m_axis_tlast))
    else $error("dump did not end on its last element");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the positional insert/delete list over its item streams.
module tb_top;
  import pidl_pkg::*;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned RANDOM_OPS = 320;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ELEM_W-1:0]   elem;
    logic [POS_W-1:0]    pos;
  } list_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   size;
    logic [ELEM_W-1:0]   elem;
    logic                valid;
    logic                last;
  } list_answer_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;

  // Operations waiting to be offered, and answers the list must still give.
  list_op_t     queued_ops[$];
  list_answer_t pending_answers[$];

  // Shadow of the list contents.
  logic [ELEM_W-1:0] shadow_cells[LIST_DEPTH];
  logic [SIZE_W-1:0] shadow_count = '0;

  int unsigned planned_size = 0;
  int unsigned total_ops = 0;
  int unsigned accepted_ops = 0;
  int unsigned mismatch_count = 0;
  int unsigned src_idle_pct = 16;
  int unsigned snk_idle_pct = 51;
  logic        op_taken = 1'b0;

  positional_insert_delete_list #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Queue one operation and keep track of the size the list will have.
  task automatic queue_op(input logic [ACTION_W-1:0] action, input logic [ELEM_W-1:0] elem,
                          input logic [POS_W-1:0] pos);
    list_op_t op;
    op.action = action;
    op.elem   = elem;
    op.pos    = pos;
    queued_ops.push_back(op);
    total_ops++;
    if (action == ACT_INSERT && pos <= planned_size && planned_size < LIST_DEPTH) begin
      planned_size++;
    end else if (action == ACT_DELETE && pos < planned_size) begin
      planned_size--;
    end
  endtask

  function automatic list_answer_t make_answer(input logic [STATUS_W-1:0] status,
                                               input logic [ELEM_W-1:0] elem,
                                               input logic valid, input logic last);
    list_answer_t a;
    a.status = status;
    a.size   = shadow_count;
    a.elem   = elem;
    a.valid  = valid;
    a.last   = last;
    return a;
  endfunction

  // Apply one accepted operation to the shadow list and queue the answers it causes.
  task automatic run_list_op(input list_op_t op);
    logic [STATUS_W-1:0] status;
    int i;
    status = ST_OK;
    case (op.action)
      ACT_INSERT: begin
        if (op.pos > shadow_count) begin
          status = ST_BADPOS;
        end else if (shadow_count >= LIST_DEPTH) begin
          status = ST_FULL;
        end else begin
          for (i = int'(shadow_count); i > int'(op.pos); i--) begin
            shadow_cells[i] = shadow_cells[i-1];
          end
          shadow_cells[op.pos] = op.elem;
          shadow_count++;
        end
      end
      ACT_DELETE: begin
        if (shadow_count == 0) begin
          status = (op.pos == 0) ? ST_EMPTY : ST_BADPOS;
        end else if (op.pos >= shadow_count) begin
          status = ST_BADPOS;
        end else begin
          for (i = int'(op.pos); i + 1 < int'(shadow_count); i++) begin
            shadow_cells[i] = shadow_cells[i+1];
          end
          shadow_count--;
        end
      end
      ACT_DUMP: begin
        if (shadow_count == 0) begin
          status = ST_EMPTY;
        end else begin
          // One answer per held element, front first, the final one marked last.
          for (i = 0; i < int'(shadow_count); i++) begin
            pending_answers.push_back(make_answer(ST_OK, shadow_cells[i], 1'b1,
                                                  i + 1 == int'(shadow_count)));
          end
          return;
        end
      end
      default: ;
    endcase
    pending_answers.push_back(make_answer(status, '0, 1'b0, 1'b1));
  endtask

  // Compare one received answer field by field with the oldest one waiting.
  task automatic check_answer(input list_answer_t got);
    list_answer_t exp;
    if (pending_answers.size() == 0) begin
      $display("%0t: unexpected item status=%0d size=%0d elem=%0h valid=%0b last=%0b",
               $time, got.status, got.size, got.elem, got.valid, got.last);
      mismatch_count++;
      return;
    end
    exp = pending_answers.pop_front();
    if (got.status !== exp.status) begin
      $display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
      mismatch_count++;
    end
    if (got.size !== exp.size) begin
      $display("%0t: size expected %0d got %0d", $time, exp.size, got.size);
      mismatch_count++;
    end
    if (got.elem !== exp.elem) begin
      $display("%0t: element expected %0h got %0h", $time, exp.elem, got.elem);
      mismatch_count++;
    end
    if (got.valid !== exp.valid) begin
      $display("%0t: element_valid expected %0b got %0b", $time, exp.valid, got.valid);
      mismatch_count++;
    end
    if (got.last !== exp.last) begin
      $display("%0t: last expected %0b got %0b", $time, exp.last, got.last);
      mismatch_count++;
    end
  endtask

  // Monitor: sample both handshakes at the rising edge.
  always @(posedge clk_i) begin
    op_taken = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_answer({m_axis_tdata[1:0], m_axis_tdata[6:2], m_axis_tdata[14:7],
                      m_axis_tuser[0], m_axis_tlast});
      end
      if (s_axis_tvalid && s_axis_tready) begin
        op_taken = 1'b1;
        run_list_op(queued_ops.pop_front());
        accepted_ops++;
      end
      // Idle pattern: sender light and receiver heavy, then swapped, then none.
      if (accepted_ops * 3 < total_ops) begin
        src_idle_pct = 16;
        snk_idle_pct = 51;
      end else if (accepted_ops * 3 < total_ops * 2) begin
        src_idle_pct = 51;
        snk_idle_pct = 16;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
    end
  end

  // Driver: offer the next queued item and set the receiver's readiness.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || op_taken) begin
        if (queued_ops.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, queued_ops[0].pos, queued_ops[0].elem};
          s_axis_tuser  <= queued_ops[0].action;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned k;
    int unsigned roll;
    int unsigned insert_bias;
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0] pos;

    // Directed part: empty-list corner cases first.
    queue_op(ACT_DUMP, 8'h00, 5'd0);
    queue_op(ACT_DELETE, 8'h00, 5'd0);
    queue_op(ACT_DELETE, 8'hff, 5'd31);
    queue_op(ACT_INSERT, 8'h12, 5'd1);
    // Insert then delete the sole element.
    queue_op(ACT_INSERT, 8'h00, 5'd0);
    queue_op(ACT_DELETE, 8'h00, 5'd0);
    // Front, back and middle inserts, then a dump and the unused action code.
    queue_op(ACT_INSERT, 8'hff, 5'd0);
    queue_op(ACT_INSERT, 8'h00, 5'd1);
    queue_op(ACT_INSERT, 8'ha5, 5'd1);
    queue_op(ACT_DUMP, 8'hff, 5'd31);
    queue_op(ACT_UNUSED, 8'hff, 5'd31);
    queue_op(ACT_DELETE, 8'h00, 5'd3);
    queue_op(ACT_DELETE, 8'h00, 5'd1);
    // Fill the list up, then hit the full and past-the-end cases.
    while (planned_size < LIST_DEPTH) begin
      queue_op(ACT_INSERT, 8'($urandom_range(0, 255)), 5'($urandom_range(0, planned_size)));
    end
    queue_op(ACT_INSERT, 8'h5a, 5'd0);
    queue_op(ACT_INSERT, 8'h5a, 5'd17);
    queue_op(ACT_DUMP, 8'h00, 5'd0);
    queue_op(ACT_DELETE, 8'h00, 5'd16);
    queue_op(ACT_DELETE, 8'h00, 5'd15);
    queue_op(ACT_DELETE, 8'h00, 5'd0);

    // Random part: edits drift the size up and down in stretches of 40.
    insert_bias = 25;
    for (k = 0; k < RANDOM_OPS; k++) begin
      if (k % 40 == 0) begin
        insert_bias = (insert_bias == 25) ? 75 : 25;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        action = ACT_UNUSED;
      end else if (roll < 15) begin
        action = ACT_DUMP;
      end else begin
        action = ($urandom_range(0, 99) < insert_bias) ? ACT_INSERT : ACT_DELETE;
      end
      // Mostly valid positions, with some spread over the whole field.
      if ($urandom_range(0, 99) < 15) begin
        pos = 5'($urandom_range(0, 31));
      end else if (action == ACT_INSERT) begin
        pos = 5'($urandom_range(0, planned_size));
      end else if (planned_size == 0) begin
        pos = 5'd0;
      end else begin
        pos = 5'($urandom_range(0, planned_size - 1));
      end
      queue_op(action, 8'($urandom_range(0, 255)), pos);
    end

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: everything offered and every answer received, then a quiet tail.
    @(posedge clk_i);
    while (queued_ops.size() != 0 || s_axis_tvalid || pending_answers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
